@@ rtl/core/account_transfer_table_assert.svh @@
// Assertion macros shared by the account transfer table checkers
`ifndef ACCOUNT_TRANSFER_TABLE_ASSERT_SVH
`define ACCOUNT_TRANSFER_TABLE_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define ATT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("account transfer table check failed");

// Next-cycle implication, off while reset is high
`define ATT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("account transfer table check failed");

// Next-cycle implication that also holds across reset
`define ATT_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("account transfer table check failed");

`endif

@@ rtl/core/att_pkg.sv @@
// Shared types and constants for the account transfer table
package att_pkg;

  localparam int ACCOUNT_SLOTS = 1024;
  localparam int SLOT_W        = $clog2(ACCOUNT_SLOTS);
  localparam int CNT_W         = SLOT_W + 1;

  localparam int ADDR_W = 64;
  localparam int BAL_W  = 64;
  localparam int AMT_W  = 32;
  localparam int IDX_W  = 10;
  localparam int CFG_W  = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // Input word layout
  localparam int IN_SLOT_LSB  = 0;
  localparam int IN_EADDR_LSB = IN_SLOT_LSB + IDX_W;
  localparam int IN_EBAL_LSB  = IN_EADDR_LSB + ADDR_W;
  localparam int IN_SADDR_LSB = IN_EBAL_LSB + BAL_W;
  localparam int IN_RADDR_LSB = IN_SADDR_LSB + ADDR_W;
  localparam int IN_AMT_LSB   = IN_RADDR_LSB + ADDR_W;
  localparam int IN_USED_W    = IN_AMT_LSB + AMT_W;
  localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

  localparam int OUT_DATA_W = 2 * BAL_W;

  typedef enum logic {
    CMD_LOAD     = 1'b0,
    CMD_TRANSFER = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_APPLIED      = 2'd0,
    ST_INSUFFICIENT = 2'd1,
    ST_NOT_FOUND    = 2'd2,
    ST_LOADED       = 2'd3
  } status_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] limit;
  } scan_req_t;

  typedef struct packed {
    logic              done;
    logic              sender_found;
    logic              receiver_found;
    logic [SLOT_W-1:0] sender_slot;
    logic [SLOT_W-1:0] receiver_slot;
  } scan_stat_t;

endpackage

@@ rtl/core/att_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module att_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/att_scan.sv @@
// Address memory and the slot-by-slot search for sender and receiver
module att_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  att_pkg::scan_req_t            req,
  input  logic [att_pkg::ADDR_W-1:0]    sender_address,
  input  logic [att_pkg::ADDR_W-1:0]    receiver_address,
  input  logic                          load_we,
  input  logic [att_pkg::SLOT_W-1:0]    load_slot,
  input  logic [att_pkg::ADDR_W-1:0]    load_address,
  output att_pkg::scan_stat_t           stat
);

  logic                         active;
  logic [att_pkg::CNT_W-1:0]    sidx;
  logic                         cmp_valid;
  logic [att_pkg::SLOT_W-1:0]   cmp_slot;
  logic [att_pkg::ADDR_W-1:0]   rd_data;
  logic                         issue;
  logic                         s_hit;
  logic                         r_hit;
  logic                         s_found_next;
  logic                         r_found_next;
  logic                         finish;

  att_ram #(
    .WIDTH(att_pkg::ADDR_W),
    .DEPTH(att_pkg::ACCOUNT_SLOTS)
  ) u_addr_ram (
    .clk  (clk),
    .we   (load_we),
    .waddr(load_slot),
    .wdata(load_address),
    .re   (issue),
    .raddr(sidx[att_pkg::SLOT_W-1:0]),
    .rdata(rd_data)
  );

  always_comb begin
    issue        = active && (sidx < req.limit);
    s_hit        = cmp_valid && !stat.sender_found && (rd_data == sender_address);
    r_hit        = cmp_valid && !stat.receiver_found && (rd_data == receiver_address);
    s_found_next = stat.sender_found | s_hit;
    r_found_next = stat.receiver_found | r_hit;
    // stop once both are known, or once the last read has been compared
    finish       = active && ((s_found_next && r_found_next) || (!issue && !cmp_valid));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      sidx      <= '0;
      cmp_valid <= 1'b0;
      cmp_slot  <= '0;
      stat      <= '0;
    end else begin
      stat.done <= finish;
      if (req.start) begin
        active              <= 1'b1;
        sidx                <= '0;
        cmp_valid           <= 1'b0;
        stat.sender_found   <= 1'b0;
        stat.receiver_found <= 1'b0;
      end else if (active) begin
        stat.sender_found   <= s_found_next;
        stat.receiver_found <= r_found_next;
        if (s_hit) begin
          stat.sender_slot <= cmp_slot;
        end
        if (r_hit) begin
          stat.receiver_slot <= cmp_slot;
        end
        cmp_valid <= issue && !finish;
        cmp_slot  <= sidx[att_pkg::SLOT_W-1:0];
        if (issue) begin
          sidx <= sidx + 1'b1;
        end
        if (finish) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/core/account_transfer_table.sv @@
// Account transfer table top level: control sequencer, balance memory and output register
//
// Holds up to 1024 accounts (address and balance) in two single-port-read memories.
// A load word writes one slot. A transfer word searches the first accounts_in_use
// slots, one slot per cycle through the address memory, stopping as soon as both
// sender and receiver are found; it then reads both balances, checks funds and, when
// funds suffice and the two slots differ, writes both back. One word is worked on at a
// time; the result waits in an output register, so the next word is taken while it is
// still unread. accounts_in_use is written through cfg_we/cfg_wdata; the user must write
// it only while the block is idle, as the block itself does not enforce this. Values
// above 1024 search all slots. Slots must be loaded before a search reaches them.
module account_transfer_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [att_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // slot_index, entry_address, entry_balance, sender_address, receiver_address, amount
  input  logic [att_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // command
  input  logic                             s_axis_tuser,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // sender_balance_after, receiver_balance_after
  output logic [att_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // status
  output logic [1:0]                       m_axis_tuser,
  output logic                             m_axis_tlast
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_RD_S,
    S_RD_R,
    S_LAT_R,
    S_CALC,
    S_WR_S,
    S_WR_R,
    S_RESULT
  } state_t;

  state_t                        state;
  logic [att_pkg::CFG_W-1:0]     accounts_in_use;
  logic                          scan_start;
  att_pkg::scan_req_t            scan_req;
  att_pkg::scan_stat_t           scan_stat;

  logic [att_pkg::ADDR_W-1:0]    sender_address;
  logic [att_pkg::ADDR_W-1:0]    receiver_address;
  logic [att_pkg::AMT_W-1:0]     amount;
  logic [att_pkg::SLOT_W-1:0]    sender_slot;
  logic [att_pkg::SLOT_W-1:0]    receiver_slot;
  logic [att_pkg::BAL_W-1:0]     sender_balance;
  logic [att_pkg::BAL_W-1:0]     receiver_balance;

  att_pkg::status_t              res_status;
  logic [att_pkg::BAL_W-1:0]     res_sender;
  logic [att_pkg::BAL_W-1:0]     res_receiver;
  logic                          res_last;

  logic                          in_accept;
  logic                          is_load;
  logic                          load_we;
  logic [att_pkg::SLOT_W-1:0]    load_slot;
  logic [att_pkg::IDX_W-1:0]     in_slot;
  logic [att_pkg::CNT_W-1:0]     limit;
  logic                          out_free;

  logic                          bal_we;
  logic [att_pkg::SLOT_W-1:0]    bal_waddr;
  logic [att_pkg::BAL_W-1:0]     bal_wdata;
  logic                          bal_re;
  logic [att_pkg::SLOT_W-1:0]    bal_raddr;
  logic [att_pkg::BAL_W-1:0]     bal_rdata;

  logic [att_pkg::BAL_W:0]       diff;
  logic [att_pkg::BAL_W-1:0]     sum;

  always_comb begin
    s_axis_tready = (state == S_IDLE);
    in_accept     = s_axis_tvalid && s_axis_tready;
    is_load       = (s_axis_tuser == att_pkg::CMD_LOAD);
    in_slot       = s_axis_tdata[att_pkg::IN_SLOT_LSB +: att_pkg::IDX_W];
    load_slot     = att_pkg::SLOT_W'(in_slot);
    // a slot beyond the table writes nothing
    load_we       = in_accept && is_load && (32'(in_slot) < 32'(att_pkg::ACCOUNT_SLOTS));
    if (32'(accounts_in_use) > 32'(att_pkg::ACCOUNT_SLOTS)) begin
      limit = att_pkg::CNT_W'(att_pkg::ACCOUNT_SLOTS);
    end else begin
      limit = att_pkg::CNT_W'(accounts_in_use);
    end
    scan_req.start = scan_start;
    scan_req.limit = limit;
    out_free       = !m_axis_tvalid || m_axis_tready;
    diff = {1'b0, sender_balance} - {{(att_pkg::BAL_W + 1 - att_pkg::AMT_W){1'b0}}, amount};
    sum  = receiver_balance + {{(att_pkg::BAL_W - att_pkg::AMT_W){1'b0}}, amount};
  end

  // balance memory port selection
  always_comb begin
    bal_we    = 1'b0;
    bal_waddr = load_slot;
    bal_wdata = s_axis_tdata[att_pkg::IN_EBAL_LSB +: att_pkg::BAL_W];
    bal_re    = (state == S_RD_S) || (state == S_RD_R);
    bal_raddr = (state == S_RD_S) ? sender_slot : receiver_slot;
    unique case (state)
      S_IDLE: begin
        bal_we = load_we;
      end
      S_WR_S: begin
        bal_we    = 1'b1;
        bal_waddr = sender_slot;
        bal_wdata = res_sender;
      end
      S_WR_R: begin
        bal_we    = 1'b1;
        bal_waddr = receiver_slot;
        bal_wdata = res_receiver;
      end
      default: begin
        bal_we = 1'b0;
      end
    endcase
  end

  att_scan u_scan (
    .clk             (clk),
    .rst             (rst),
    .req             (scan_req),
    .sender_address  (sender_address),
    .receiver_address(receiver_address),
    .load_we         (load_we),
    .load_slot       (load_slot),
    .load_address    (s_axis_tdata[att_pkg::IN_EADDR_LSB +: att_pkg::ADDR_W]),
    .stat            (scan_stat)
  );

  att_ram #(
    .WIDTH(att_pkg::BAL_W),
    .DEPTH(att_pkg::ACCOUNT_SLOTS)
  ) u_bal_ram (
    .clk  (clk),
    .we   (bal_we),
    .waddr(bal_waddr),
    .wdata(bal_wdata),
    .re   (bal_re),
    .raddr(bal_raddr),
    .rdata(bal_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      accounts_in_use <= att_pkg::CFG_RESET;
      scan_start      <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      scan_start <= 1'b0;
      if (cfg_we) begin
        accounts_in_use <= cfg_wdata;
      end
      // the result state loads the output register itself
      if (m_axis_tready && (state != S_RESULT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            sender_address   <= s_axis_tdata[att_pkg::IN_SADDR_LSB +: att_pkg::ADDR_W];
            receiver_address <= s_axis_tdata[att_pkg::IN_RADDR_LSB +: att_pkg::ADDR_W];
            amount           <= s_axis_tdata[att_pkg::IN_AMT_LSB +: att_pkg::AMT_W];
            res_last         <= s_axis_tlast;
            if (is_load) begin
              res_status   <= att_pkg::ST_LOADED;
              res_sender   <= '0;
              res_receiver <= '0;
              state        <= S_RESULT;
            end else begin
              scan_start <= 1'b1;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_stat.done) begin
            sender_slot   <= scan_stat.sender_slot;
            receiver_slot <= scan_stat.receiver_slot;
            if (scan_stat.sender_found && scan_stat.receiver_found) begin
              state <= S_RD_S;
            end else begin
              res_status   <= att_pkg::ST_NOT_FOUND;
              res_sender   <= '0;
              res_receiver <= '0;
              state        <= S_RESULT;
            end
          end
        end
        S_RD_S: begin
          state <= S_RD_R;
        end
        S_RD_R: begin
          sender_balance <= bal_rdata;
          state          <= S_LAT_R;
        end
        S_LAT_R: begin
          receiver_balance <= bal_rdata;
          state            <= S_CALC;
        end
        S_CALC: begin
          priority if (diff[att_pkg::BAL_W]) begin
            res_status   <= att_pkg::ST_INSUFFICIENT;
            res_sender   <= sender_balance;
            res_receiver <= receiver_balance;
            state        <= S_RESULT;
          end else if (sender_slot == receiver_slot) begin
            // paying oneself leaves the balance as it was
            res_status   <= att_pkg::ST_APPLIED;
            res_sender   <= sender_balance;
            res_receiver <= sender_balance;
            state        <= S_RESULT;
          end else begin
            res_status   <= att_pkg::ST_APPLIED;
            res_sender   <= diff[att_pkg::BAL_W-1:0];
            res_receiver <= sum;
            state        <= S_WR_S;
          end
        end
        S_WR_S: begin
          state <= S_WR_R;
        end
        S_WR_R: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {res_receiver, res_sender};
            m_axis_tuser  <= res_status;
            m_axis_tlast  <= res_last;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/att_checker.sv @@
// Port-level checks for the account transfer table, bound to the top level
`include "account_transfer_table_assert.svh"

module att_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [att_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic [1:0]                      m_axis_tuser,
  input logic                            m_axis_tlast
);

  // a stalled result word holds
  `ATT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // one word in flight: input closes right after an accept
  `ATT_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // loads and misses report zero balances
  `ATT_ASSERT_NOW(a_zero_balances,
    m_axis_tvalid && (m_axis_tuser == att_pkg::ST_LOADED || m_axis_tuser == att_pkg::ST_NOT_FOUND),
    m_axis_tdata == '0)

  // reset drops any pending result
  `ATT_ASSERT_NEXT_ALWAYS(a_reset_clears, rst, !m_axis_tvalid)

endmodule

bind account_transfer_table att_checker u_att_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

@@ dv/tb_account_transfer_table.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the account transfer table: load and transfer words
module tb_account_transfer_table;
  import att_pkg::*;

  localparam int POOL_N = 12;
  localparam bit [ADDR_W-1:0] ADDR_P = 64'h0123_4567_89AB_CDEF;
  localparam bit [ADDR_W-1:0] ADDR_Q = 64'hFEDC_BA98_7654_3210;
  localparam bit [ADDR_W-1:0] ADDR_R = 64'h8000_0000_0000_0000;
  localparam bit [ADDR_W-1:0] ADDR_S = 64'h5555_5555_5555_5555;
  localparam bit [ADDR_W-1:0] ADDR_T = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam bit [ADDR_W-1:0] ADDR_U = 64'h0F0F_0F0F_0F0F_0F0F;
  localparam bit [ADDR_W-1:0] ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    cmd_t            command;
    bit [IDX_W-1:0]  slot;
    bit [ADDR_W-1:0] entry_addr;
    bit [BAL_W-1:0]  entry_bal;
    bit [ADDR_W-1:0] sender_addr;
    bit [ADDR_W-1:0] receiver_addr;
    bit [AMT_W-1:0]  amount;
    bit              batch_end;
  } acct_word_t;

  typedef struct {
    status_t        status;
    bit [BAL_W-1:0] sender_bal;
    bit [BAL_W-1:0] receiver_bal;
    bit             batch_done;
  } acct_result_t;

  class ledger_model;
    bit [ADDR_W-1:0] addr_mem [ACCOUNT_SLOTS];
    bit [BAL_W-1:0]  bal_mem [ACCOUNT_SLOTS];
    bit              written [ACCOUNT_SLOTS];
    bit [CFG_W-1:0]  search_size;
    acct_result_t    awaited [$];
    int              errors;

    function new();
      search_size = CFG_RESET;
      errors = 0;
    endfunction

    function int searched();
      return (search_size > ACCOUNT_SLOTS) ? ACCOUNT_SLOTS : int'(search_size);
    endfunction

    function int find_slot(bit [ADDR_W-1:0] addr);
      for (int i = 0; i < searched(); i++)
        if (addr_mem[i] == addr) return i;
      return -1;
    endfunction

    // true when a search for addr stops before any slot that was never loaded
    function bit reach_ok(bit [ADDR_W-1:0] addr);
      for (int i = 0; i < searched(); i++) begin
        if (!written[i]) return 1'b0;
        if (addr_mem[i] == addr) return 1'b1;
      end
      return 1'b1;
    endfunction

    function void note_word(acct_word_t w);
      acct_result_t r;
      int s;
      int d;
      r.status = ST_LOADED;
      r.sender_bal = '0;
      r.receiver_bal = '0;
      r.batch_done = w.batch_end;
      if (w.command == CMD_LOAD) begin
        addr_mem[w.slot] = w.entry_addr;
        bal_mem[w.slot] = w.entry_bal;
        written[w.slot] = 1'b1;
      end else begin
        s = find_slot(w.sender_addr);
        d = find_slot(w.receiver_addr);
        if (s < 0 || d < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          // subtract then add, so a self transfer ends where it began
          if (bal_mem[s] >= w.amount) begin
            bal_mem[s] -= w.amount;
            bal_mem[d] += w.amount;
            r.status = ST_APPLIED;
          end else begin
            r.status = ST_INSUFFICIENT;
          end
          r.sender_bal = bal_mem[s];
          r.receiver_bal = bal_mem[d];
        end
      end
      awaited.push_back(r);
    endfunction

    function void check_word(logic [1:0] status, logic [BAL_W-1:0] sbal,
                             logic [BAL_W-1:0] rbal, logic done);
      acct_result_t e;
      if (awaited.size() == 0) begin
        errors++;
        $error("result word with nothing awaited: status %0d", status);
        return;
      end
      e = awaited.pop_front();
      if (status !== e.status) begin
        errors++;
        $error("status: expected %0d, got %0d", e.status, status);
      end
      if (sbal !== e.sender_bal) begin
        errors++;
        $error("sender_balance_after: expected %h, got %h", e.sender_bal, sbal);
      end
      if (rbal !== e.receiver_bal) begin
        errors++;
        $error("receiver_balance_after: expected %h, got %h", e.receiver_bal, rbal);
      end
      if (done !== e.batch_done) begin
        errors++;
        $error("batch_done: expected %0d, got %0d", e.batch_done, done);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  ledger_model     ledger = new();
  bit              idle_on = 1'b1;
  bit              hold_request = 1'b0;
  bit [ADDR_W-1:0] addr_pool [POOL_N];

  account_transfer_table dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [IN_DATA_W-1:0] pack_word(acct_word_t w);
    logic [IN_DATA_W-1:0] v;
    v = '0;
    v[IN_SLOT_LSB  +: IDX_W]  = w.slot;
    v[IN_EADDR_LSB +: ADDR_W] = w.entry_addr;
    v[IN_EBAL_LSB  +: BAL_W]  = w.entry_bal;
    v[IN_SADDR_LSB +: ADDR_W] = w.sender_addr;
    v[IN_RADDR_LSB +: ADDR_W] = w.receiver_addr;
    v[IN_AMT_LSB   +: AMT_W]  = w.amount;
    return v;
  endfunction

  function automatic acct_word_t load_word(int slot, bit [ADDR_W-1:0] addr,
                                           bit [BAL_W-1:0] bal, bit last);
    acct_word_t w;
    w = '{CMD_LOAD, IDX_W'(slot), addr, bal, '0, '0, '0, last};
    return w;
  endfunction

  function automatic acct_word_t transfer_word(bit [ADDR_W-1:0] from, bit [ADDR_W-1:0] to,
                                               bit [AMT_W-1:0] amt, bit last);
    acct_word_t w;
    w = '{CMD_TRANSFER, '0, '0, '0, from, to, amt, last};
    return w;
  endfunction

  function automatic bit [BAL_W-1:0] pick_balance();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(0, 1000));
      2: return ~64'($urandom_range(0, 1000));   // close to wrapping
      default: return 64'($urandom);
    endcase
  endfunction

  function automatic bit [ADDR_W-1:0] pick_address();
    if ($urandom_range(0, 3) != 0) return addr_pool[$urandom_range(0, POOL_N - 1)];
    return {$urandom, $urandom};
  endfunction

  function automatic bit [AMT_W-1:0] pick_amount(bit [BAL_W-1:0] avail);
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return AMT_W'($urandom_range(0, 2000));
      2: return (avail > 64'hFFFF_FFFF) ? '1 : avail[AMT_W-1:0];
      3: return (avail >= 64'hFFFF_FFFF) ? '1 : avail[AMT_W-1:0] + 1'b1;
      default: return ($urandom_range(0, 1) != 0) ? '0 : '1;
    endcase
  endfunction

  // span: slots whose addresses transfers mostly draw on; all of them are loaded
  function automatic acct_word_t random_word(int load_pct, int span);
    acct_word_t w;
    int s;
    int d;
    w.command = ($urandom_range(0, 99) < load_pct) ? CMD_LOAD : CMD_TRANSFER;
    w.slot = ($urandom_range(0, 7) == 0) ? IDX_W'($urandom)
                                         : IDX_W'($urandom_range(0, span - 1));
    w.entry_addr = pick_address();
    w.entry_bal = pick_balance();
    s = $urandom_range(0, span - 1);
    d = $urandom_range(0, span - 1);
    w.sender_addr = ($urandom_range(0, 9) != 0 && ledger.written[s]) ? ledger.addr_mem[s]
                                                                      : pick_address();
    w.receiver_addr = ($urandom_range(0, 9) != 0 && ledger.written[d]) ? ledger.addr_mem[d]
                                                                        : pick_address();
    // keep every search inside loaded slots
    if (!ledger.reach_ok(w.sender_addr)) w.sender_addr = ledger.addr_mem[0];
    if (!ledger.reach_ok(w.receiver_addr)) w.receiver_addr = ledger.addr_mem[0];
    s = ledger.find_slot(w.sender_addr);
    w.amount = pick_amount((s >= 0) ? ledger.bal_mem[s] : 64'($urandom));
    w.batch_end = ($urandom_range(0, 3) == 0);
    return w;
  endfunction

  task automatic send_word(acct_word_t w);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_word(w);
    s_axis_tuser  <= w.command;
    s_axis_tlast  <= w.batch_end;
    do @(posedge clk); while (!s_axis_tready);
    ledger.note_word(w);
  endtask

  task automatic drain_phase();
    s_axis_tvalid <= 1'b0;
    while (ledger.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic set_search_size(bit [CFG_W-1:0] value);
    drain_phase();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    ledger.search_size = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic fill_slots(int count);
    for (int i = 0; i < count; i++)
      if (!ledger.written[i]) send_word(load_word(i, pick_address(), pick_balance(), 1'b0));
  endtask

  task automatic run_random(int count, int load_pct, int span);
    repeat (count) send_word(random_word(load_pct, span));
  endtask

  initial begin : drain_results
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        ledger.check_word(m_axis_tuser, m_axis_tdata[BAL_W-1:0],
                          m_axis_tdata[BAL_W +: BAL_W], m_axis_tlast);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 2000;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    addr_pool[0] = '0;
    addr_pool[1] = ONES;
    addr_pool[2] = ADDR_P;
    addr_pool[3] = ADDR_Q;
    addr_pool[4] = ADDR_R;
    addr_pool[5] = ADDR_S;
    addr_pool[6] = ADDR_T;
    addr_pool[7] = ADDR_U;
    for (int i = 8; i < POOL_N; i++) addr_pool[i] = {$urandom, $urandom};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, duplicates, wrap, self transfer, missing parties
    set_search_size(11'd8);
    send_word(load_word(0, '0, 64'd1000, 1'b0));
    send_word(load_word(1, ONES, ONES, 1'b1));
    send_word(load_word(2, ADDR_P, '0, 1'b0));
    send_word(load_word(3, ADDR_Q, 64'hFFFF_FFFF_FFFF_FF00, 1'b0));
    send_word(load_word(4, ADDR_R, 64'd5000, 1'b0));
    send_word(load_word(5, ADDR_P, 64'd777, 1'b0));
    send_word(load_word(6, ADDR_S, 64'h1_0000_0000, 1'b0));
    send_word(load_word(7, ADDR_T, 64'd100, 1'b0));
    send_word(load_word(1023, ADDR_U, 64'd12345, 1'b0));
    send_word(transfer_word('0, ADDR_R, 32'd300, 1'b0));
    send_word(transfer_word(ADDR_S, ADDR_Q, 32'h1FF, 1'b0));
    send_word(transfer_word(ADDR_T, '0, 32'd101, 1'b0));
    send_word(transfer_word(ADDR_T, '0, 32'd100, 1'b1));
    send_word(transfer_word(ONES, ADDR_P, 32'hFFFF_FFFF, 1'b0));
    send_word(transfer_word(ADDR_R, ADDR_R, 32'd10, 1'b0));
    send_word(transfer_word(ADDR_T, ADDR_T, 32'd1, 1'b1));
    send_word(transfer_word(ADDR_U, ADDR_P, 32'd1, 1'b0));
    send_word(transfer_word(ADDR_R, 64'h1234, 32'd1, 1'b0));
    send_word(transfer_word(64'h1234, 64'h5678, 32'd1, 1'b0));
    send_word(transfer_word(ADDR_S, ADDR_P, 32'd0, 1'b1));

    set_search_size(11'd0);
    run_random(20, 30, 8);

    set_search_size(11'd64);
    fill_slots(64);
    hold_request = 1'b1;
    run_random(100, 30, 64);

    set_search_size(11'd1);
    run_random(40, 40, 2);

    set_search_size(11'd1024);
    run_random(100, 20, 64);

    set_search_size(11'($urandom_range(2, 64)));
    run_random(100, 30, ledger.searched());

    set_search_size(11'd2047);
    run_random(60, 20, 64);

    idle_on = 1'b0;
    set_search_size(11'd16);
    run_random(80, 30, 16);

    drain_phase();
    repeat (1100) @(posedge clk);
    if (ledger.errors == 0 && ledger.awaited.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
